### sv/wct_pkg.sv
// Shared types, constants and helpers for the weighted choice table.
// Used by the controller, the datapath and the top level.
package wct_pkg;

   localparam int KEY_W    = 8;
   localparam int TAG_W    = 8;
   localparam int CHANCE_W = 17;

   localparam logic [CHANCE_W-1:0] LIMIT_CUM = 17'd99999;
   localparam logic [CHANCE_W-1:0] FULL_CUM  = 17'd100000;

   localparam logic [1:0] CMD_ADD  = 2'd0;
   localparam logic [1:0] CMD_EDIT = 2'd1;
   localparam logic [1:0] CMD_DRAW = 2'd2;
   localparam logic [1:0] CMD_NONE = 2'd3;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_REFUSED = 2'd1;
   localparam logic [1:0] STATUS_MISS    = 2'd2;

   typedef struct packed {
      logic [KEY_W-1:0]    key;
      logic [TAG_W-1:0]    tag;
      logic [CHANCE_W-1:0] chance;
      logic [CHANCE_W-1:0] cum;
   } wct_entry_type;

   localparam int ENTRY_W = $bits(wct_entry_type);

   typedef enum logic [3:0] {
      OP_NONE      = 4'd0,
      OP_ADD       = 4'd1,
      OP_SCAN_RD   = 4'd2,
      OP_SCAN_CHK  = 4'd3,
      OP_SHIFT_RD  = 4'd4,
      OP_SHIFT_WR  = 4'd5,
      OP_FINAL     = 4'd6,
      OP_PROBE_RD  = 4'd7,
      OP_PROBE_CHK = 4'd8,
      OP_PREV_RD   = 4'd9,
      OP_PREV_CHK  = 4'd10
   } wct_op_type;

   typedef struct packed {
      wct_op_type op;
      logic       latch;
      logic       load_rsp;
   } wct_cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic       count_zero;
      logic       add_ok;
      logic       match;
      logic       idx_last;
      logic       probe_ge;
      logic       c_zero;
      logic       probe_more;
      logic       prev_lt;
      logic       prev_more;
   } wct_stat_type;

   // Store sums above the limit as a full 100 percent.
   function automatic logic [CHANCE_W-1:0] clamp_cum(input logic [CHANCE_W:0] sum);
      if (sum > {1'b0, LIMIT_CUM}) begin
         return FULL_CUM;
      end
      return sum[CHANCE_W-1:0];
   endfunction

endpackage

### sv/wct_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/wct_ctrl.sv
// Sequencer for the weighted choice table: add, edit scan/shift, draw search.
// Depends on wct_pkg; drives the datapath through wct_cmd_type.
module wct_ctrl import wct_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  wct_stat_type stat,
   output wct_cmd_type  cmd
);

   typedef enum logic [12:0] {
      S_IDLE      = 13'b0000000000001,
      S_DECODE    = 13'b0000000000010,
      S_ADD       = 13'b0000000000100,
      S_SCAN_RD   = 13'b0000000001000,
      S_SCAN_CHK  = 13'b0000000010000,
      S_SHIFT_RD  = 13'b0000000100000,
      S_SHIFT_WR  = 13'b0000001000000,
      S_FINAL     = 13'b0000010000000,
      S_PROBE_RD  = 13'b0000100000000,
      S_PROBE_CHK = 13'b0001000000000,
      S_PREV_RD   = 13'b0010000000000,
      S_PREV_CHK  = 13'b0100000000000,
      S_DONE      = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      load_rsp;

   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      cmd.latch = req_tvalid && (state_ff == S_IDLE);
      load_rsp  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.command)
               CMD_ADD:  state_in = S_ADD;
               CMD_EDIT: state_in = stat.count_zero ? S_ADD : S_SCAN_RD;
               CMD_DRAW: state_in = stat.count_zero ? S_DONE : S_PROBE_RD;
               CMD_NONE: state_in = S_DONE;
            endcase
         end
         S_ADD: begin
            cmd.op   = OP_ADD;
            state_in = S_DONE;
         end
         S_SCAN_RD: begin
            cmd.op   = OP_SCAN_RD;
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            cmd.op = OP_SCAN_CHK;
            if (stat.match) begin
               state_in = stat.idx_last ? S_FINAL : S_SHIFT_RD;
            end else begin
               // no match here: scan on, or fall back to an add after the last entry
               state_in = stat.idx_last ? S_ADD : S_SCAN_RD;
            end
         end
         S_SHIFT_RD: begin
            cmd.op   = OP_SHIFT_RD;
            state_in = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            cmd.op   = OP_SHIFT_WR;
            state_in = stat.idx_last ? S_FINAL : S_SHIFT_RD;
         end
         S_FINAL: begin
            cmd.op   = OP_FINAL;
            state_in = S_DONE;
         end
         S_PROBE_RD: begin
            cmd.op   = OP_PROBE_RD;
            state_in = S_PROBE_CHK;
         end
         S_PROBE_CHK: begin
            cmd.op = OP_PROBE_CHK;
            if (stat.probe_ge) begin
               state_in = stat.c_zero ? S_DONE : S_PREV_RD;
            end else begin
               state_in = stat.probe_more ? S_PROBE_RD : S_DONE;
            end
         end
         S_PREV_RD: begin
            cmd.op   = OP_PREV_RD;
            state_in = S_PREV_CHK;
         end
         S_PREV_CHK: begin
            cmd.op = OP_PREV_CHK;
            if (stat.prev_lt) begin
               state_in = S_DONE;
            end else begin
               state_in = stat.prev_more ? S_PROBE_RD : S_DONE;
            end
         end
         S_DONE: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      cmd.load_rsp = load_rsp;
   end

   assign req_tready   = (state_ff == S_IDLE);
   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign rsp_tvalid   = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_DECODE))
      else $error("accepted transaction did not advance to decode");

endmodule

### sv/wct_dpath.sv
// Datapath of the weighted choice table: entry RAM, counters, search bounds,
// result and output registers. Depends on wct_pkg and wct_ram.
module wct_dpath import wct_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  wct_cmd_type         cmd,
   output wct_stat_type        stat,
   input  logic [1:0]          in_command,
   input  logic [KEY_W-1:0]    in_key,
   input  logic [TAG_W-1:0]    in_tag,
   input  logic [CHANCE_W-1:0] in_chance,
   input  logic [CHANCE_W-1:0] in_point,
   output logic [1:0]          out_status,
   output logic [KEY_W-1:0]    out_key,
   output logic [TAG_W-1:0]    out_tag,
   output logic                out_found
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   // request registers
   logic [1:0]          command_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [TAG_W-1:0]    tag_ff;
   logic [CHANCE_W-1:0] chance_ff, point_ff;

   // table state
   logic [CW-1:0]       count_ff, count_in;
   logic [CHANCE_W-1:0] last_cum_ff, last_cum_in;

   // edit and draw working registers
   logic [CW-1:0]       idx_ff, idx_in;
   logic [CHANCE_W-1:0] base_ff, base_in;
   logic [CHANCE_W-1:0] old_ff, old_in;
   logic [TAG_W-1:0]    mtag_ff, mtag_in;
   logic [CW-1:0]       first_ff, first_in;
   logic [CW-1:0]       last1_ff, last1_in;
   logic [CW-1:0]       c_ff, c_in;
   logic [KEY_W-1:0]    hit_key_ff, hit_key_in;
   logic [TAG_W-1:0]    hit_tag_ff, hit_tag_in;

   // pending result and output register
   logic [1:0]          res_status_ff, res_status_in;
   logic [KEY_W-1:0]    res_key_ff, res_key_in;
   logic [TAG_W-1:0]    res_tag_ff, res_tag_in;
   logic                res_found_ff, res_found_in;
   logic [1:0]          rsp_status_ff;
   logic [KEY_W-1:0]    rsp_key_ff;
   logic [TAG_W-1:0]    rsp_tag_ff;
   logic                rsp_found_ff;

   // RAM port
   logic                wr_en;
   logic [AW-1:0]       wr_addr, rd_addr;
   wct_entry_type       wr_entry, rd_entry;
   logic [ENTRY_W-1:0]  rd_word;

   logic [CW-1:0]       idx_inc, c_probe, c_inc;
   logic [CHANCE_W-1:0] add_cum, final_cum, passed_cum;
   logic                add_ok;

   assign idx_inc    = CW'(idx_ff + 1'b1);
   assign c_inc      = CW'(c_ff + 1'b1);
   assign c_probe    = CW'(first_ff + ((CW'(last1_ff - first_ff - 1'b1)) >> 1));
   assign add_ok     = (count_ff < DEPTH_C) && (last_cum_ff <= LIMIT_CUM);
   assign add_cum    = clamp_cum({1'b0, last_cum_ff} + {1'b0, chance_ff});
   assign final_cum  = clamp_cum({1'b0, base_ff} + {1'b0, chance_ff});
   assign passed_cum = (rd_entry.cum > old_ff) ? (rd_entry.cum - old_ff) : '0;
   assign rd_entry   = wct_entry_type'(rd_word);

   assign stat.command    = command_ff;
   assign stat.count_zero = (count_ff == '0);
   assign stat.add_ok     = add_ok;
   assign stat.match      = (rd_entry.key == key_ff);
   assign stat.idx_last   = (idx_inc == count_ff);
   assign stat.probe_ge   = (rd_entry.cum >= point_ff);
   assign stat.c_zero     = (c_ff == '0);
   assign stat.probe_more = (last1_ff > c_inc);
   assign stat.prev_lt    = (rd_entry.cum < point_ff);
   assign stat.prev_more  = (c_ff > first_ff);

   always_comb begin
      count_in      = count_ff;
      last_cum_in   = last_cum_ff;
      idx_in        = idx_ff;
      base_in       = base_ff;
      old_in        = old_ff;
      mtag_in       = mtag_ff;
      first_in      = first_ff;
      last1_in      = last1_ff;
      c_in          = c_ff;
      hit_key_in    = hit_key_ff;
      hit_tag_in    = hit_tag_ff;
      res_status_in = res_status_ff;
      res_key_in    = res_key_ff;
      res_tag_in    = res_tag_ff;
      res_found_in  = res_found_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[AW-1:0];
      wr_entry      = '{key: key_ff, tag: tag_ff, chance: chance_ff, cum: add_cum};
      rd_addr       = idx_ff[AW-1:0];

      if (cmd.latch) begin
         idx_in        = '0;
         base_in       = '0;
         first_in      = '0;
         last1_in      = count_ff;
         // a draw reports a miss unless the search hits
         res_status_in = (in_command == CMD_DRAW) ? STATUS_MISS : STATUS_DONE;
         res_key_in    = '0;
         res_tag_in    = '0;
         res_found_in  = 1'b0;
      end

      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_ADD: begin
            if (add_ok) begin
               wr_en         = 1'b1;
               count_in      = CW'(count_ff + 1'b1);
               last_cum_in   = add_cum;
               res_status_in = STATUS_DONE;
            end else begin
               res_status_in = STATUS_REFUSED;
            end
         end
         OP_SCAN_RD: begin
            rd_addr = idx_ff[AW-1:0];
         end
         OP_SCAN_CHK: begin
            idx_in = idx_inc;
            if (rd_entry.key == key_ff) begin
               old_in  = rd_entry.chance;
               mtag_in = rd_entry.tag;
            end else begin
               base_in = rd_entry.cum;
            end
         end
         OP_SHIFT_RD: begin
            rd_addr = idx_ff[AW-1:0];
         end
         OP_SHIFT_WR: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(idx_ff - 1'b1);
            wr_entry = '{key: rd_entry.key, tag: rd_entry.tag,
                         chance: rd_entry.chance, cum: passed_cum};
            base_in  = passed_cum;
            idx_in   = idx_inc;
         end
         OP_FINAL: begin
            wr_en        = 1'b1;
            wr_addr      = AW'(count_ff - 1'b1);
            wr_entry     = '{key: key_ff, tag: mtag_ff, chance: chance_ff, cum: final_cum};
            last_cum_in  = final_cum;
            res_found_in = 1'b1;
         end
         OP_PROBE_RD: begin
            c_in    = c_probe;
            rd_addr = c_probe[AW-1:0];
         end
         OP_PROBE_CHK: begin
            if (rd_entry.cum >= point_ff) begin
               hit_key_in = rd_entry.key;
               hit_tag_in = rd_entry.tag;
               if (c_ff == '0) begin
                  res_status_in = STATUS_DONE;
                  res_key_in    = rd_entry.key;
                  res_tag_in    = rd_entry.tag;
               end
            end else begin
               first_in = c_inc;
            end
         end
         OP_PREV_RD: begin
            rd_addr = AW'(c_ff - 1'b1);
         end
         OP_PREV_CHK: begin
            if (rd_entry.cum < point_ff) begin
               res_status_in = STATUS_DONE;
               res_key_in    = hit_key_ff;
               res_tag_in    = hit_tag_ff;
            end else begin
               last1_in = c_ff;
            end
         end
         default: begin
         end
      endcase
   end

   wct_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         last_cum_ff <= '0;
      end else begin
         count_ff    <= count_in;
         last_cum_ff <= last_cum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         command_ff <= in_command;
         key_ff     <= in_key;
         tag_ff     <= in_tag;
         chance_ff  <= in_chance;
         point_ff   <= in_point;
      end
      idx_ff        <= idx_in;
      base_ff       <= base_in;
      old_ff        <= old_in;
      mtag_ff       <= mtag_in;
      first_ff      <= first_in;
      last1_ff      <= last1_in;
      c_ff          <= c_in;
      hit_key_ff    <= hit_key_in;
      hit_tag_ff    <= hit_tag_in;
      res_status_ff <= res_status_in;
      res_key_ff    <= res_key_in;
      res_tag_ff    <= res_tag_in;
      res_found_ff  <= res_found_in;
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_key_ff    <= res_key_ff;
         rsp_tag_ff    <= res_tag_ff;
         rsp_found_ff  <= res_found_ff;
      end
   end

   assign out_status = rsp_status_ff;
   assign out_key    = rsp_key_ff;
   assign out_tag    = rsp_tag_ff;
   assign out_found  = rsp_found_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count above table depth");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      last_cum_ff <= FULL_CUM)
      else $error("last cumulative value above full scale");

   a_empty_total: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (last_cum_ff == '0))
      else $error("empty table with nonzero total");

   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_ADD && add_ok) |=> (count_ff == CW'($past(count_ff) + 1'b1)))
      else $error("accepted add did not grow the table");

endmodule

### sv/weighted_choice_table.sv
// Top level of the weighted choice table: stream ports, controller, datapath.
// Depends on wct_pkg, wct_ctrl, wct_dpath (and wct_ram inside the datapath).
//
//   channel | direction | tdata fields (low first)                | tuser
//   req     | in        | entry_key, entry_tag, chance, random_value | command
//   rsp     | out       | selected_key, selected_tag                  | status, edit_found
//
// Per transaction: an add writes one entry at the end; an edit reads and checks
// entry by entry through the single RAM read port for the key scan, then moves
// each later entry down for the shift; a draw halves the range per search step,
// reading a probe and, on a hit, the entry before it, each registered RAM read checked in its own state.
// Reset clears the entry count and the running total; the RAM is not cleared.
// A finished result waits in the output register while the next transaction
// is accepted; the block starts a new one only after the previous result is loaded.
module weighted_choice_table import wct_pkg::*; #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] entry_key, [15:8] entry_tag, [32:16] chance, [49:33] random_value
   input  logic [55:0] req_tdata,
   // [1:0] command
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] selected_key, [15:8] selected_tag
   output logic [15:0] rsp_tdata,
   // [1:0] status, [2] edit_found
   output logic [2:0]  rsp_tuser
);

   wct_cmd_type  cmd;
   wct_stat_type stat;

   wct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   wct_dpath #(
      .DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .in_command (req_tuser),
      .in_key     (req_tdata[7:0]),
      .in_tag     (req_tdata[15:8]),
      .in_chance  (req_tdata[32:16]),
      .in_point   (req_tdata[49:33]),
      .out_status (rsp_tuser[1:0]),
      .out_key    (rsp_tdata[7:0]),
      .out_tag    (rsp_tdata[15:8]),
      .out_found  (rsp_tuser[2])
   );

endmodule
